[rtl/rcfw_pkg.sv]
// shared types, character codes and helper functions for the radix converter
package rcfw_pkg;

  // bits of quotient produced per cycle by the shared divider
  localparam int DIV_RADIX_BITS = 8;

  // length of the error word
  localparam int ERR_LEN = 5;

  localparam logic [6:0] CHAR_SPACE   = 7'h20;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_NINE    = 7'h39;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
  localparam logic [6:0] CHAR_UPPER_E = 7'h45;
  localparam logic [6:0] CHAR_UPPER_R = 7'h52;
  localparam logic [6:0] CHAR_UPPER_O = 7'h4F;

  localparam logic [5:0] DIGIT_BAD      = 6'h3F;
  localparam logic [3:0] DECIMAL_DIGITS = 4'd10;
  localparam logic [4:0] BASE_MIN       = 5'd2;
  localparam logic [4:0] BASE_MAX       = 5'd16;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_START,
    ST_DIV,
    ST_CHECK,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accum;
    logic start;
    logic div_step;
    logic set_err;
    logic emit;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic start_err;
    logic div_done;
    logic quot_zero;
    logic count_full;
    logic out_free;
    logic pos_last;
  } dp_status_t;

  // digit value 0..35, or DIGIT_BAD outside 0-9 / A-Z
  function automatic logic [5:0] char_value(input logic [6:0] c);
    logic [5:0] v;
    v = DIGIT_BAD;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = 6'(c - CHAR_ZERO);
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = 6'(c - CHAR_UPPER_A) + 6'(DECIMAL_DIGITS);
    end
    return v;
  endfunction

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d < DECIMAL_DIGITS) begin
      c = CHAR_ZERO + 7'(d);
    end else begin
      c = CHAR_UPPER_A + 7'(d - DECIMAL_DIGITS);
    end
    return c;
  endfunction

  // letters of the error word by position
  function automatic logic [6:0] err_letter(input logic [2:0] i);
    logic [6:0] c;
    case (i)
      3'd0:    c = CHAR_UPPER_E;
      3'd1:    c = CHAR_UPPER_R;
      3'd2:    c = CHAR_UPPER_R;
      3'd3:    c = CHAR_UPPER_O;
      3'd4:    c = CHAR_UPPER_R;
      default: c = CHAR_SPACE;
    endcase
    return c;
  endfunction

endpackage

[rtl/rcfw_ctrl.sv]
// sequencing state machine of the radix converter
module rcfw_ctrl
  import rcfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accum = 1'b1;
          if (in_last) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = status.start_err ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.quot_zero) begin
          state_next = ST_EMIT;
        end else if (status.count_full) begin
          cmd.set_err = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pos_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_ACCUM;
          end
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

[rtl/rcfw_datapath.sv]
// accumulator, shared divider, digit store and output register
module rcfw_datapath
  import rcfw_pkg::*;
#(
  parameter int FIELD_WIDTH = 7,
  parameter int VALUE_BITS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic [6:0] digit_char,
  input  logic [4:0] from_base,
  input  logic [4:0] to_base,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [6:0] out_char,
  output logic       is_error,
  output logic       end_of_line
);

  localparam int IDX_W     = (FIELD_WIDTH > 1) ? $clog2(FIELD_WIDTH) : 1;
  localparam int CNT_W     = $clog2(FIELD_WIDTH + 1);
  localparam int CMP_W     = CNT_W + 1;
  localparam int LET_W     = IDX_W + 3;
  localparam int DIV_STEPS = (VALUE_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int QUOT_BITS = DIV_STEPS * DIV_RADIX_BITS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int BASE_W    = 5;
  localparam int PROD_BITS = VALUE_BITS + BASE_W;
  localparam int ERR_PAD   = (FIELD_WIDTH >= ERR_LEN) ? FIELD_WIDTH - ERR_LEN : 0;

  logic [VALUE_BITS-1:0] acc;
  logic                  error_seen;
  logic [4:0]            tb;
  logic [QUOT_BITS-1:0]  quot;
  logic [4:0]            rem;
  logic [STEP_W-1:0]     step;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      pos;
  logic                  line_err;
  logic [3:0]            digits [FIELD_WIDTH];

  logic [5:0]            d;
  logic                  bad;
  logic [PROD_BITS-1:0]  prod;
  logic                  ovf;
  logic [4:0]            rem_step;
  logic [DIV_RADIX_BITS-1:0] qbits;
  logic [DIV_RADIX_BITS-1:0] quot_top;
  logic                  step_last;
  logic [IDX_W-1:0]      rd_idx;
  logic [LET_W-1:0]      letter_pos;
  logic                  pad_sel;

  // horner step: value * base + digit by shift and add
  always_comb begin
    d   = char_value(digit_char);
    bad = (from_base < BASE_MIN) || (from_base > BASE_MAX) ||
          (d == DIGIT_BAD) || (d >= 6'(from_base));
    prod = PROD_BITS'(d);
    for (int i = 0; i < BASE_W; i++) begin
      if (from_base[i]) begin
        prod = prod + (PROD_BITS'(acc) << i);
      end
    end
    ovf = |prod[PROD_BITS-1:VALUE_BITS];
  end

  // restoring division, DIV_RADIX_BITS quotient bits per cycle
  always_comb begin
    quot_top = quot[QUOT_BITS-1 -: DIV_RADIX_BITS];
    rem_step = rem;
    qbits    = '0;
    for (int i = DIV_RADIX_BITS - 1; i >= 0; i--) begin
      rem_step = {rem_step[3:0], quot_top[i]};
      if (rem_step >= tb) begin
        rem_step = rem_step - tb;
        qbits[i] = 1'b1;
      end
    end
  end

  assign step_last = (step == STEP_W'(DIV_STEPS - 1));

  // kind of character for the current line position
  always_comb begin
    rd_idx     = IDX_W'(FIELD_WIDTH - 1) - pos;
    letter_pos = LET_W'(pos) - LET_W'(ERR_PAD);
    if (line_err) begin
      pad_sel = (CMP_W'(pos) < CMP_W'(ERR_PAD));
    end else begin
      pad_sel = (CMP_W'(pos) + CMP_W'(count) < CMP_W'(FIELD_WIDTH));
    end
  end

  always_comb begin
    status.start_err  = error_seen || (tb < BASE_MIN) || (tb > BASE_MAX);
    status.div_done   = step_last;
    status.quot_zero  = (quot == '0);
    status.count_full = (count == CNT_W'(FIELD_WIDTH));
    status.out_free   = !out_valid || out_ready;
    status.pos_last   = (pos == IDX_W'(FIELD_WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
      step       <= '0;
      count      <= '0;
      pos        <= '0;
      line_err   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        acc        <= '0;
        error_seen <= 1'b0;
      end else if (cmd.accum) begin
        if (bad) begin
          error_seen <= 1'b1;
        end else if (!error_seen) begin
          if (ovf) begin
            error_seen <= 1'b1;
          end else begin
            acc <= prod[VALUE_BITS-1:0];
          end
        end
      end
      if (cmd.start) begin
        step     <= '0;
        count    <= '0;
        pos      <= '0;
        line_err <= status.start_err;
      end
      if (cmd.div_step) begin
        if (step_last) begin
          step  <= '0;
          count <= count + 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
      if (cmd.set_err) begin
        line_err <= 1'b1;
      end
      if (cmd.emit) begin
        pos <= pos + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      tb <= to_base;
    end
    if (cmd.start) begin
      quot <= QUOT_BITS'(acc);
      rem  <= '0;
    end
    if (cmd.div_step) begin
      quot <= {quot[QUOT_BITS-DIV_RADIX_BITS-1:0], qbits};
      if (step_last) begin
        rem                       <= '0;
        digits[count[IDX_W-1:0]]  <= rem_step[3:0];
      end else begin
        rem <= rem_step;
      end
    end
    if (cmd.emit) begin
      if (pad_sel) begin
        out_char <= CHAR_SPACE;
      end else if (line_err) begin
        out_char <= err_letter(letter_pos[2:0]);
      end else begin
        out_char <= digit_ascii(digits[rd_idx]);
      end
      is_error    <= line_err;
      end_of_line <= status.pos_last;
    end
  end

endmodule

[rtl/radix_converter_fixed_width.sv]
// top level of the radix converter with a fixed-width output line
//
// input channel: one transaction per ascii character of a numeral, most
// significant first, with from_base, to_base and last_char. characters
// that are not last are taken one per cycle and folded into the value.
// output channel: after the last character, FIELD_WIDTH transactions that
// spell the value in to_base, right-justified with spaces, or the word
// ERROR padded alike; end_of_line marks the final one, is_error the whole
// line when the numeral was bad, overflowed or needs too many digits, or
// when to_base is out of range. after the last character is taken, a
// setup state checks the bases and loads the divider; then for each result
// digit the divider runs and a check follows; then the line characters are
// loaded one per cycle while the receiver keeps up. the shared divider
// retires 8 quotient bits a cycle. no new character is taken while a line
// is being built or sent; the output register lets the next numeral start
// while the final character still waits. a stalled receiver holds the line
// character by character. reset (synchronous, active high) clears the
// value, the error flag and the output valid; the block is ready as soon
// as reset is released.
module radix_converter_fixed_width
  import rcfw_pkg::*;
#(
  parameter int FIELD_WIDTH = 7,
  parameter int VALUE_BITS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] digit_char,
  input  logic [4:0] from_base,
  input  logic [4:0] to_base,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       is_error,
  output logic       end_of_line
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: accumulate, divide digit by digit, then send the line
  rcfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last_char),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // value accumulator, divider, digit store and output register
  rcfw_datapath #(
    .FIELD_WIDTH (FIELD_WIDTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .digit_char  (digit_char),
    .from_base   (from_base),
    .to_base     (to_base),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .is_error    (is_error),
    .end_of_line (end_of_line)
  );

`ifndef ASSERT_OFF
  // a line character is only loaded when the output register can take it
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("line character loaded over a pending transaction");

  // no input transaction while the divider is running
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !in_ready)
    else $error("input accepted during division");

  // after the final line character is loaded the block takes input again
  a_ready_after_line: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.pos_last |=> in_ready && out_valid && end_of_line)
    else $error("line did not end cleanly");
`endif

endmodule

[sim/radix_line_checker.sv]
// line predictor and output checker for the radix converter testbench
`timescale 1ns / 1ps
module radix_line_checker
  import rcfw_pkg::*;
#(
  parameter int FIELD_WIDTH = 7,
  parameter int VALUE_BITS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [6:0] digit_char,
  input  logic [4:0] from_base,
  input  logic [4:0] to_base,
  input  logic       last_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_char,
  input  logic       is_error,
  input  logic       end_of_line,
  output int         fail_count,
  output int         chars_pending
);

  typedef struct packed {
    logic [6:0] ch;
    logic       err;
    logic       eol;
  } line_char_t;

  localparam logic [39:0] ERR_WORD = "ERROR";

  logic [VALUE_BITS-1:0] numeral_value;
  logic                  numeral_bad;
  line_char_t            line_queue[$];

  // digit value of an ascii character, -1 when not 0-9 / A-Z
  function automatic int digit_of(input logic [6:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return int'(c) - int'(CHAR_ZERO);
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return int'(c) - int'(CHAR_UPPER_A) + 10;
    end
    return -1;
  endfunction

  task automatic fold_char(input logic [6:0] c, input logic [4:0] fb);
    int                    d;
    logic [VALUE_BITS-1:0] all_ones;
    logic [VALUE_BITS-1:0] dv;
    logic [VALUE_BITS-1:0] bv;
    d = digit_of(c);
    all_ones = '1;
    if (fb < BASE_MIN || fb > BASE_MAX || d < 0 || d >= int'(fb)) begin
      numeral_bad = 1'b1;
    end else if (!numeral_bad) begin
      dv = VALUE_BITS'(d);
      bv = VALUE_BITS'(fb);
      // the next value would not fit the accumulator
      if (numeral_value > (all_ones - dv) / bv) begin
        numeral_bad = 1'b1;
      end else begin
        numeral_value = numeral_value * bv + dv;
      end
    end
  endtask

  task automatic predict_line(input logic [4:0] tb);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] bv;
    logic [3:0]            digs[FIELD_WIDTH];
    int                    n;
    int                    pad;
    int                    d;
    logic                  bad;
    line_char_t            e;
    bad = numeral_bad || tb < BASE_MIN || tb > BASE_MAX;
    n = 0;
    v = numeral_value;
    bv = VALUE_BITS'(tb);
    if (!bad) begin
      if (v == 0) begin
        digs[0] = 4'd0;
        n = 1;
      end
      while (v != 0 && !bad) begin
        if (n >= FIELD_WIDTH) begin
          bad = 1'b1;
        end else begin
          digs[n] = 4'(v % bv);
          n++;
          v = v / bv;
        end
      end
    end
    for (int k = 0; k < FIELD_WIDTH; k++) begin
      if (bad) begin
        pad = (FIELD_WIDTH >= 5) ? FIELD_WIDTH - 5 : 0;
        e.ch = (k < pad) ? CHAR_SPACE : 7'(ERR_WORD[8 * (4 - (k - pad)) +: 8]);
      end else begin
        pad = FIELD_WIDTH - n;
        if (k < pad) begin
          e.ch = CHAR_SPACE;
        end else begin
          d = int'(digs[FIELD_WIDTH - 1 - k]);
          e.ch = (d < 10) ? CHAR_ZERO + 7'(d) : CHAR_UPPER_A + 7'(d - 10);
        end
      end
      e.err = bad;
      e.eol = (k == FIELD_WIDTH - 1);
      line_queue = {line_queue, e};
    end
    numeral_value = '0;
    numeral_bad = 1'b0;
  endtask

  always @(posedge clk) begin
    line_char_t want;
    line_char_t got;
    if (rst) begin
      numeral_value = '0;
      numeral_bad = 1'b0;
      line_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{ch: out_char, err: is_error, eol: end_of_line};
        if (line_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction, expected none, got ch %h err %b eol %b",
                   $time, got.ch, got.err, got.eol);
        end else begin
          want = line_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch, expected ch %h err %b eol %b, got ch %h err %b eol %b",
                     $time, want.ch, want.err, want.eol, got.ch, got.err, got.eol);
          end
        end
      end
      if (in_valid && in_ready) begin
        fold_char(digit_char, from_base);
        if (last_char) begin
          predict_line(to_base);
        end
      end
    end
    chars_pending = line_queue.size();
  end

endmodule

[sim/radix_converter_fixed_width_tb.sv]
// testbench top for the radix converter: stimulus, handshake pressure and verdict
`timescale 1ns / 1ps
module radix_converter_fixed_width_tb
  import rcfw_pkg::*;
();

  localparam int FIELD_WIDTH  = 7;
  localparam int VALUE_BITS   = 64;
  localparam int RANDOM_CHARS = 150;
  // characters near the end of the run sent with no idling on either side
  localparam int CALM_TAIL    = 25;
  localparam int LONG_HOLD    = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [6:0] digit_char = '0;
  logic [4:0] from_base = BASE_MIN;
  logic [4:0] to_base = BASE_MIN;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       is_error;
  logic       end_of_line;

  int fail_count;
  int chars_pending;

  // shared with the receiver process
  bit idle_on = 1'b1;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  int chars_sent = 0;

  always #10 clk = ~clk;

  radix_converter_fixed_width #(
    .FIELD_WIDTH(FIELD_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .digit_char (digit_char),
    .from_base  (from_base),
    .to_base    (to_base),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .is_error   (is_error),
    .end_of_line(end_of_line)
  );

  radix_line_checker #(
    .FIELD_WIDTH(FIELD_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .digit_char   (digit_char),
    .from_base    (from_base),
    .to_base      (to_base),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .is_error     (is_error),
    .end_of_line  (end_of_line),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  // one input transaction; valid stays high into the next call unless a gap
  // is inserted first, so it is never lowered and raised in the same step
  task automatic send_char(input logic [6:0] c, input logic [4:0] fb,
                           input logic [4:0] tb, input logic last);
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    digit_char <= c;
    from_base  <= fb;
    to_base    <= tb;
    last_char  <= last;
    // in_ready is read before this edge's updates land, so this is the
    // value the block saw at the edge
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  // whole numeral from text, last flag on the final character
  task automatic send_text(input string s, input logic [4:0] fb, input logic [4:0] tb);
    for (int i = 0; i < s.len(); i++) begin
      send_char(7'(s[i]), fb, tb, i == s.len() - 1);
    end
  endtask

  function automatic logic [6:0] ascii_digit(input int d);
    return (d < 10) ? CHAR_ZERO + 7'(d) : CHAR_UPPER_A + 7'(d - 10);
  endfunction

  // receiver: random stall bursts, one long hold-off on request, and none
  // during the calm tail
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        // long hold-off so the output register and the line builder fill up
        // and the block has to drop in_ready while characters keep coming
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // main sequence: reset, directed numerals, random numerals, drain, verdict
  initial begin
    int         target;
    int         kind;
    int         len;
    int         d;
    int         bad_pos;
    logic [4:0] fb;
    logic [4:0] tb;
    logic [6:0] c;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // zero value prints a single 0
    send_text("0", 5'd10, 5'd2);
    // seven binary digits fill the line exactly
    send_text("7F", 5'd16, 5'd2);
    // eight binary digits do not fit
    send_text("FF", 5'd16, 5'd2);
    // digit beyond the source base
    send_text("Z", 5'd16, 5'd10);
    // lowercase is not a digit
    send_text("a", 5'd16, 5'd10);
    // lowest and highest character codes, both outside the digit set
    send_char(7'h00, 5'd10, 5'd10, 1'b0);
    send_char(7'h7F, 5'd10, 5'd10, 1'b1);
    // a bad character in the middle poisons the whole numeral
    send_text("1a1", 5'd16, 5'd10);
    // source base out of range on both sides
    send_text("1", 5'd0, 5'd10);
    send_text("1", 5'd1, 5'd10);
    send_text("1", 5'd17, 5'd10);
    send_text("1", 5'd31, 5'd10);
    // target base out of range on both sides
    send_text("5", 5'd10, 5'd0);
    send_text("5", 5'd10, 5'd1);
    send_text("5", 5'd10, 5'd17);
    send_text("5", 5'd10, 5'd31);
    // both base extremes in range
    send_text("F", 5'd16, 5'd16);
    send_text("1", 5'd2, 5'd2);

    target = chars_sent + RANDOM_CHARS;
    hold_request = 1'b1;

    // seventeen hex digits overflow the 64-bit accumulator
    send_text("FFFFFFFFFFFFFFFFF", 5'd16, 5'd10);

    while (chars_sent < target) begin
      // stretches with and without idling
      idle_on = ($urandom_range(0, 2) != 0);
      quiet   = (chars_sent >= target - CALM_TAIL);
      kind    = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: any code, any base
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_char(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                    5'($urandom_range(0, 31)), i == len - 1);
        end
      end else begin
        fb = 5'($urandom_range(2, 16));
        tb = 5'($urandom_range(2, 16));
        if (kind == 1) begin
          // long numerals, often past the accumulator or the line width
          len = $urandom_range(12, 18);
          fb  = ($urandom_range(0, 1) == 0) ? 5'd16 : fb;
        end else if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(5, 9);
        end else begin
          len = $urandom_range(1, 4);
        end
        // broken numeral: one position carries an arbitrary code
        bad_pos = (kind == 2) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          d = $urandom_range(0, int'(fb) - 1);
          c = (i == bad_pos) ? 7'($urandom_range(0, 127)) : ascii_digit(d);
          send_char(c, fb, tb, i == len - 1);
        end
      end
    end

    idle_on = 1'b0;
    in_valid <= 1'b0;
    // one more edge so the checker has taken the final transaction
    @(posedge clk);
    wait (chars_pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
